// File: design/ptes_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ptes_pkg - shared types and constants for the periodic tick event slots
// Action codes, default sizes and the command/status records between the
// top level and the slot cells.
// ----------------------------------------------------------------------------
package ptes_pkg;

   localparam int SLOTS_DEF      = 8;
   localparam int COUNT_BITS_DEF = 32;

   localparam int ACTION_W   = 2;
   localparam int PERIOD_W   = 32;
   localparam int SELECT_W   = 4;
   localparam int FIRED_W    = 8;
   localparam int GRANTED_W  = 3;
   localparam int COUNT_W    = 4;

   typedef enum logic [ACTION_W-1:0] {
      ACT_TICK      = 2'd0,
      ACT_SET       = 2'd1,
      ACT_CLEAR     = 2'd2,
      ACT_CLEAR_ALL = 2'd3
   } action_type;

   // Command broadcast to one cell for the beat being accepted
   typedef struct packed {
      logic tick;
      logic set;
      logic clear_hit;
      logic clear_all;
   } cell_cmd_type;

   // What one cell reports back for the same beat
   typedef struct packed {
      logic active;
      logic fired;
      logic claimed;
      logic freed;
   } cell_status_type;

endpackage : ptes_pkg
`default_nettype wire

// File: design/periodic_tick_event_slots.sv
`default_nettype none
// A result beat appears in the cycle after its request beat is taken.
// Throughput: one request beat per cycle; a waiting result does not block the
//   next request unless the result side stalls.
// Every beat is handled by the row of slot cells, the free-slot claim token
//   rippling through the row from slot 0 upwards.
// Reset (synchronous, active high) frees every slot and empties the output.
// ----------------------------------------------------------------------------
// periodic_tick_event_slots - bank of periodic countdown slots
// A tick decrements every active slot, a set claims the lowest free slot, a
// clear frees one slot and a clear-all frees every slot.
// ----------------------------------------------------------------------------
module periodic_tick_event_slots #(
   parameter int SLOTS      = ptes_pkg::SLOTS_DEF,
   parameter int COUNT_BITS = ptes_pkg::COUNT_BITS_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // request channel
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire logic [ptes_pkg::ACTION_W-1:0]      req_action,
   input  wire logic [ptes_pkg::PERIOD_W-1:0]      req_period_ticks,
   input  wire logic [ptes_pkg::SELECT_W-1:0]      req_slot_select,
   // response channel
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic [ptes_pkg::FIRED_W-1:0]            rsp_fired_mask,
   output logic [ptes_pkg::GRANTED_W-1:0]          rsp_granted_slot,
   output logic                                    rsp_set_failed,
   output logic [ptes_pkg::COUNT_W-1:0]            rsp_active_count
);
   import ptes_pkg::*;

   localparam int TOTAL_W = $clog2(SLOTS + 1);
   localparam int MASK_N  = (SLOTS < FIRED_W) ? SLOTS : FIRED_W;

   logic                  accept;
   logic                  is_tick, is_set, is_clear, is_clear_all;
   logic [COUNT_BITS-1:0] period;

   cell_cmd_type          cmd    [SLOTS];
   cell_status_type       status [SLOTS];
   logic [SLOTS:0]        claim;
   logic [SLOTS-1:0]      active_vec;
   logic [SLOTS-1:0]      claimed_vec;

   logic [TOTAL_W-1:0]    total_ff, total_in;
   logic                  freed;
   logic                  failed;

   logic [FIRED_W-1:0]    fired_mask;
   logic [GRANTED_W-1:0]  granted;

   logic                  rsp_valid_ff,        rsp_valid_in;
   logic [FIRED_W-1:0]    rsp_fired_mask_ff,   rsp_fired_mask_in;
   logic [GRANTED_W-1:0]  rsp_granted_slot_ff, rsp_granted_slot_in;
   logic                  rsp_set_failed_ff,   rsp_set_failed_in;
   logic [COUNT_W-1:0]    rsp_active_count_ff, rsp_active_count_in;

   // Hold the request side only while a finished result is being stalled
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;

   assign is_tick      = accept & (req_action == ACT_TICK);
   assign is_set       = accept & (req_action == ACT_SET);
   assign is_clear     = accept & (req_action == ACT_CLEAR);
   assign is_clear_all = accept & (req_action == ACT_CLEAR_ALL);

   // Period taken modulo 2^COUNT_BITS (zero-extended when the count is wider)
   assign period = COUNT_BITS'(req_period_ticks);

   // Broadcast the command; the clear hits only the addressed slot, and a
   // select beyond the bank hits nothing.
   always_comb begin
      for (int i = 0; i < SLOTS; i++) begin
         cmd[i].tick      = is_tick;
         cmd[i].set       = is_set;
         cmd[i].clear_all = is_clear_all;
         cmd[i].clear_hit = is_clear && (32'(req_slot_select) == i);
      end
   end

   // Slot 0 is always offered the claim token; a busy cell passes it on
   assign claim[0] = 1'b1;

   for (genvar g = 0; g < SLOTS; g++) begin : g_cell
      ptes_cell #(
         .COUNT_BITS (COUNT_BITS)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .cmd       (cmd[g]),
         .period    (period),
         .claim_in  (claim[g]),
         .claim_out (claim[g+1]),
         .status    (status[g])
      );
      assign active_vec[g]  = status[g].active;
      assign claimed_vec[g] = status[g].claimed;
   end

   // Token left over at the end of the row: every slot is busy
   assign failed = is_set & claim[SLOTS];

   // Gather the per-slot reports
   always_comb begin
      fired_mask = '0;
      granted    = '0;
      freed      = 1'b0;
      for (int i = 0; i < MASK_N; i++) begin
         fired_mask[i] = status[i].fired;
      end
      for (int i = 0; i < SLOTS; i++) begin
         if (status[i].claimed) begin
            granted = GRANTED_W'(i);
         end
         freed = freed | status[i].freed;
      end
   end

   // Advance the active count alongside the cells
   always_comb begin
      total_in = total_ff;
      if (is_clear_all) begin
         total_in = '0;
      end else if (is_set && !failed) begin
         total_in = total_ff + TOTAL_W'(1);
      end else if (freed) begin
         total_in = total_ff - TOTAL_W'(1);
      end
   end

   // Output register: load on accept, drop when taken
   always_comb begin
      rsp_valid_in        = rsp_valid_ff;
      rsp_fired_mask_in   = rsp_fired_mask_ff;
      rsp_granted_slot_in = rsp_granted_slot_ff;
      rsp_set_failed_in   = rsp_set_failed_ff;
      rsp_active_count_in = rsp_active_count_ff;
      if (accept) begin
         rsp_valid_in        = 1'b1;
         rsp_fired_mask_in   = fired_mask;
         rsp_granted_slot_in = granted;
         rsp_set_failed_in   = failed;
         rsp_active_count_in = COUNT_W'(total_in);
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_fired_mask_ff   <= rsp_fired_mask_in;
      rsp_granted_slot_ff <= rsp_granted_slot_in;
      rsp_set_failed_ff   <= rsp_set_failed_in;
      rsp_active_count_ff <= rsp_active_count_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_fired_mask   = rsp_fired_mask_ff;
   assign rsp_granted_slot = rsp_granted_slot_ff;
   assign rsp_set_failed   = rsp_set_failed_ff;
   assign rsp_active_count = rsp_active_count_ff;

   // ---------------------------------------------------------------- checks
   // The running count always matches the active flags held in the cells
   assert property (@(posedge clock) disable iff (reset)
      int'(total_ff) == $countones(active_vec))
      else $error("active count out of step with slot cells");

   // At most one cell takes the claim token on a beat
   assert property (@(posedge clock) disable iff (reset)
      $onehot0(claimed_vec))
      else $error("more than one slot claimed");

   // A successful set adds exactly one active slot
   assert property (@(posedge clock) disable iff (reset)
      (is_set && !claim[SLOTS]) |=> (total_ff == $past(total_ff) + TOTAL_W'(1)))
      else $error("set did not add one active slot");

endmodule : periodic_tick_event_slots
`default_nettype wire

// File: design/ptes_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ptes_cell - one periodic countdown slot
// Holds active flag, reload and countdown; passes the free-slot claim token
// on to the next cell when it is already busy.
// ----------------------------------------------------------------------------
module ptes_cell #(
   parameter int COUNT_BITS = ptes_pkg::COUNT_BITS_DEF
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire ptes_pkg::cell_cmd_type    cmd,
   input  wire logic [COUNT_BITS-1:0]     period,
   input  wire logic                      claim_in,
   output logic                           claim_out,
   output ptes_pkg::cell_status_type      status
);
   import ptes_pkg::*;

   logic                  active_ff,    active_in;
   logic [COUNT_BITS-1:0] reload_ff,    reload_in;
   logic [COUNT_BITS-1:0] countdown_ff, countdown_in;
   logic                  take;
   logic                  fire;

   assign take      = cmd.set & claim_in & ~active_ff;
   assign claim_out = claim_in & active_ff;
   // decrementing a count of one gives zero: fire and reload
   assign fire      = cmd.tick & active_ff & (countdown_ff == COUNT_BITS'(1));

   always_comb begin
      active_in    = active_ff;
      reload_in    = reload_ff;
      countdown_in = countdown_ff;
      if (cmd.clear_all || cmd.clear_hit) begin
         active_in = 1'b0;
      end else if (take) begin
         active_in    = 1'b1;
         reload_in    = period;
         countdown_in = period;
      end else if (cmd.tick && active_ff) begin
         countdown_in = fire ? reload_ff : countdown_ff - COUNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
      end else begin
         active_ff <= active_in;
      end
   end

   always_ff @(posedge clock) begin
      reload_ff    <= reload_in;
      countdown_ff <= countdown_in;
   end

   assign status.active  = active_ff;
   assign status.fired   = fire;
   assign status.claimed = take;
   assign status.freed   = cmd.clear_hit & active_ff;

endmodule : ptes_cell
`default_nettype wire
